// ===== rtl/json_token_emitter_assert.svh =====
// Assertion macros for the JSON token emitter.
// Used by json_token_emitter.sv; expects clk and rst_n in scope.
`ifndef JSON_TOKEN_EMITTER_ASSERT_SVH
`define JSON_TOKEN_EMITTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define JTE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("json_token_emitter assertion failed");

// Next-cycle implication, disabled during reset.
`define JTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("json_token_emitter assertion failed");

`endif

// ===== rtl/jte_pkg.sv =====
// Shared types and constants for the JSON token emitter.
// No dependencies; imported by every module of the block.
package jte_pkg;

    localparam int JTE_MAX_DEPTH = 16;
    localparam int DEPTH_W       = 5;
    localparam int SPACE_W       = 6;
    localparam int Q_DEPTH       = 2;
    localparam int QP_W          = 1;
    localparam int NUM_DIGITS    = 20;

    localparam logic [3:0] ACT_OPEN_OBJ = 4'd0;
    localparam logic [3:0] ACT_OPEN_ARR = 4'd1;
    localparam logic [3:0] ACT_CLOSE    = 4'd2;
    localparam logic [3:0] ACT_ITEM     = 4'd3;
    localparam logic [3:0] ACT_QUOTE    = 4'd4;
    localparam logic [3:0] ACT_STRING   = 4'd5;
    localparam logic [3:0] ACT_COLON    = 4'd6;
    localparam logic [3:0] ACT_LITERAL  = 4'd7;
    localparam logic [3:0] ACT_INTEGER  = 4'd8;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_CLOSE     = 3'd1;
    localparam logic [2:0] ERR_ITEM      = 3'd2;
    localparam logic [2:0] ERR_COLON     = 3'd3;
    localparam logic [2:0] ERR_TOO_DEEP  = 3'd4;

    localparam logic [1:0] KIND_BYTES = 2'd0;
    localparam logic [1:0] KIND_INT   = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    // Command handed from front to back.
    typedef struct packed {
        logic [1:0]              kind;
        logic [2:0]              err;
        logic [2:0]              nbytes;
        logic [5:0][7:0]         bytes;
        logic                    ind_en;
        logic                    ipos;
        logic [DEPTH_W-1:0]      lvl;
        logic [63:0]             number;
    } cmd_t;

endpackage

// ===== rtl/jte_if.sv =====
// Valid/ready channel interfaces for the JSON token emitter.
// No dependencies.
interface jte_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         action;
    logic               pretty_mode;
    logic [7:0]         data_byte;
    logic signed [63:0] number;

    modport source (output valid, action, pretty_mode, data_byte, number, input ready);
    modport sink   (input valid, action, pretty_mode, data_byte, number, output ready);
endinterface

interface jte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic [2:0] error;

    modport source (output valid, out_byte, last, error, input ready);
    modport sink   (input valid, out_byte, last, error, output ready);
endinterface

// ===== rtl/jte_front.sv =====
// Front end: accepts tokens, checks them against the container state,
// updates that state and queues byte commands. Depends on jte_pkg, jte_if.
module jte_front import jte_pkg::*; #(
    parameter int MAX_DEPTH = JTE_MAX_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    jte_in_if.sink      in_ch,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic                stack_reg [MAX_DEPTH];
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic                comma_reg, comma_next;
    logic                pretty_reg, pretty_next;
    logic                accept, push, stack_we, top_obj;
    logic [DEPTH_W-1:0]  top_pos;
    cmd_t                cmd;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
    endfunction

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && !q_full;
    assign top_pos     = depth_reg - 1'b1;
    assign top_obj     = stack_reg[top_pos[IDX_W-1:0]];

    always_comb
    begin
        cmd         = '0;
        cmd.kind    = KIND_BYTES;
        cmd.number  = in_ch.number;
        push        = 1'b0;
        stack_we    = 1'b0;
        depth_next  = depth_reg;
        comma_next  = comma_reg;
        pretty_next = pretty_reg;
        case (in_ch.action) inside
            ACT_OPEN_OBJ, ACT_OPEN_ARR:
            begin
                push = 1'b1;
                if (depth_reg == DEPTH_W'(MAX_DEPTH))
                begin
                    cmd.kind = KIND_ERR;
                    cmd.err  = ERR_TOO_DEEP;
                end
                else
                begin
                    pretty_next  = in_ch.pretty_mode;
                    cmd.nbytes   = 3'd1;
                    cmd.bytes[0] = (in_ch.action == ACT_OPEN_OBJ) ? 8'h7B : 8'h5B;
                    stack_we     = 1'b1;
                    depth_next   = depth_reg + 1'b1;
                    comma_next   = 1'b0;
                end
            end
            ACT_CLOSE:
            begin
                push = 1'b1;
                if (depth_reg == '0)
                begin
                    cmd.kind = KIND_ERR;
                    cmd.err  = ERR_CLOSE;
                end
                else
                begin
                    depth_next   = top_pos;
                    comma_next   = 1'b1;
                    cmd.nbytes   = 3'd1;
                    cmd.bytes[0] = top_obj ? 8'h7D : 8'h5D;
                    cmd.ind_en   = pretty_reg;
                    cmd.lvl      = top_pos;
                end
            end
            ACT_ITEM:
            begin
                if (depth_reg == '0)
                begin
                    push     = 1'b1;
                    cmd.kind = KIND_ERR;
                    cmd.err  = ERR_ITEM;
                end
                else
                begin
                    push       = comma_reg || pretty_reg;
                    cmd.ind_en = pretty_reg;
                    cmd.lvl    = depth_reg;
                    if (comma_reg)
                    begin
                        cmd.nbytes   = 3'd1;
                        cmd.bytes[0] = 8'h2C;
                        cmd.ipos     = 1'b1;
                    end
                    else
                    begin
                        comma_next = 1'b1;
                    end
                end
            end
            ACT_QUOTE:
            begin
                push         = 1'b1;
                cmd.nbytes   = 3'd1;
                cmd.bytes[0] = 8'h22;
            end
            ACT_STRING:
            begin
                push         = 1'b1;
                cmd.nbytes   = 3'd2;
                cmd.bytes[0] = 8'h5C;
                unique case (in_ch.data_byte)
                    8'h22:   cmd.bytes[1] = 8'h22;
                    8'h5C:   cmd.bytes[1] = 8'h5C;
                    8'h0A:   cmd.bytes[1] = 8'h6E;
                    8'h0D:   cmd.bytes[1] = 8'h72;
                    8'h09:   cmd.bytes[1] = 8'h74;
                    8'h0C:   cmd.bytes[1] = 8'h66;
                    8'h08:   cmd.bytes[1] = 8'h62;
                    default:
                    begin
                        if (in_ch.data_byte < 8'h20)
                        begin
                            // \u00xx form for remaining control bytes
                            cmd.nbytes   = 3'd6;
                            cmd.bytes[1] = 8'h75;
                            cmd.bytes[2] = 8'h30;
                            cmd.bytes[3] = 8'h30;
                            cmd.bytes[4] = hex_char(in_ch.data_byte[7:4]);
                            cmd.bytes[5] = hex_char(in_ch.data_byte[3:0]);
                        end
                        else
                        begin
                            cmd.nbytes   = 3'd1;
                            cmd.bytes[0] = in_ch.data_byte;
                        end
                    end
                endcase
            end
            ACT_COLON:
            begin
                push = 1'b1;
                if (depth_reg == '0 || !top_obj)
                begin
                    cmd.kind = KIND_ERR;
                    cmd.err  = ERR_COLON;
                end
                else
                begin
                    cmd.nbytes   = pretty_reg ? 3'd2 : 3'd1;
                    cmd.bytes[0] = 8'h3A;
                    cmd.bytes[1] = 8'h20;
                end
            end
            ACT_LITERAL:
            begin
                push         = 1'b1;
                cmd.nbytes   = 3'd1;
                cmd.bytes[0] = in_ch.data_byte;
            end
            ACT_INTEGER:
            begin
                push     = 1'b1;
                cmd.kind = KIND_INT;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    assign q_push = accept && push;
    assign q_cmd  = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= '0;
            comma_reg  <= 1'b0;
            pretty_reg <= 1'b0;
        end
        else if (accept)
        begin
            depth_reg  <= depth_next;
            comma_reg  <= comma_next;
            pretty_reg <= pretty_next;
        end
    end

    // container marks: written on open, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && stack_we)
            stack_reg[depth_reg[IDX_W-1:0]] <= (in_ch.action == ACT_OPEN_OBJ);
    end

endmodule

// ===== rtl/jte_fifo.sv =====
// Two-entry command queue between front and back.
// Depends on jte_pkg.
module jte_fifo import jte_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    cmd_t              mem_reg [Q_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QP_W:0]     count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == (QP_W+1)'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/jte_back.sv =====
// Back end: expands queued commands into output bytes, including indent
// runs and decimal conversion. Depends on jte_pkg, jte_if.
module jte_back import jte_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_head,
    output logic       q_pop,
    jte_out_if.source  out_ch
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_BYTES  = 3'd1;
    localparam logic [2:0] ST_CONV   = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_SIGN   = 3'd4;
    localparam logic [2:0] ST_DIGITS = 3'd5;
    localparam logic [2:0] ST_ERR    = 3'd6;

    localparam int BCD_W = 4 * NUM_DIGITS;

    logic [2:0]          state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [2:0]          idx_reg, idx_next;
    logic                ind_pend_reg, ind_pend_next;
    logic                nl_sent_reg, nl_sent_next;
    logic [SPACE_W-1:0]  sp_reg, sp_next;
    logic [63:0]         bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next, bcd_adj;
    logic [5:0]          cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic [4:0]          dig_reg, dig_next, dig_top;
    logic                out_valid_reg;
    logic [7:0]          out_byte_reg;
    logic                out_last_reg;
    logic [2:0]          out_err_reg;
    logic                step, emit, emit_last, ind_now, ind_done;
    logic [7:0]          emit_byte;
    logic [2:0]          emit_err;

    assign step = !out_valid_reg || out_ch.ready;

    // double-dabble adjust, one per digit
    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    // most significant nonzero digit
    always_comb
    begin
        dig_top = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] != 4'd0)
                dig_top = 5'(d);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        ind_pend_next = ind_pend_reg;
        nl_sent_next  = nl_sent_reg;
        sp_next       = sp_reg;
        bin_next      = bin_reg;
        bcd_next      = bcd_reg;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;
        dig_next      = dig_reg;
        q_pop         = 1'b0;
        emit          = 1'b0;
        emit_byte     = 8'h00;
        emit_last     = 1'b0;
        emit_err      = ERR_NONE;
        ind_now       = ind_pend_reg && (idx_reg == {2'b00, cmd_reg.ipos});
        ind_done      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop         = 1'b1;
                    cmd_next      = q_head;
                    idx_next      = '0;
                    ind_pend_next = q_head.ind_en;
                    nl_sent_next  = 1'b0;
                    neg_next      = q_head.number[63];
                    bin_next      = q_head.number[63] ? (~q_head.number + 64'd1)
                                                      : q_head.number;
                    bcd_next      = '0;
                    cnt_next      = '0;
                    unique case (q_head.kind)
                        KIND_ERR: state_next = ST_ERR;
                        KIND_INT: state_next = ST_CONV;
                        default:  state_next = ST_BYTES;
                    endcase
                end
            end
            ST_ERR:
            begin
                if (step)
                begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    emit_err   = cmd_reg.err;
                    state_next = ST_IDLE;
                end
            end
            ST_BYTES:
            begin
                if (step)
                begin
                    emit = 1'b1;
                    if (ind_now)
                    begin
                        if (!nl_sent_reg)
                        begin
                            emit_byte    = 8'h0A;
                            nl_sent_next = 1'b1;
                            sp_next      = {cmd_reg.lvl, 1'b0};
                            ind_done     = (cmd_reg.lvl == '0);
                        end
                        else
                        begin
                            emit_byte = 8'h20;
                            sp_next   = sp_reg - 1'b1;
                            ind_done  = (sp_reg == SPACE_W'(1));
                        end
                        if (ind_done)
                            ind_pend_next = 1'b0;
                        emit_last = ind_done && (idx_reg == cmd_reg.nbytes);
                    end
                    else
                    begin
                        emit_byte = cmd_reg.bytes[idx_reg];
                        idx_next  = idx_reg + 1'b1;
                        emit_last = ((idx_reg + 3'd1) == cmd_reg.nbytes) && !ind_pend_reg;
                    end
                    if (emit_last)
                        state_next = ST_IDLE;
                end
            end
            ST_CONV:
            begin
                {bcd_next, bin_next} = {bcd_adj, bin_reg} << 1;
                cnt_next             = cnt_reg + 1'b1;
                if (cnt_reg == 6'd63)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                dig_next   = dig_top;
                state_next = neg_reg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN:
            begin
                if (step)
                begin
                    emit       = 1'b1;
                    emit_byte  = 8'h2D;
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (step)
                begin
                    emit      = 1'b1;
                    emit_byte = {4'h3, bcd_reg[4*dig_reg +: 4]};
                    emit_last = (dig_reg == '0);
                    dig_next  = dig_reg - 1'b1;
                    if (emit_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        ind_pend_reg <= ind_pend_next;
        nl_sent_reg  <= nl_sent_next;
        sp_reg       <= sp_next;
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        cnt_reg      <= cnt_next;
        neg_reg      <= neg_next;
        dig_reg      <= dig_next;
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
            out_err_reg  <= emit_err;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.last     = out_last_reg;
    assign out_ch.error    = out_err_reg;

endmodule

// ===== rtl/json_token_emitter.sv =====
// json_token_emitter: JSON writer tokens in, JSON text out one byte per transaction.
// Path: a token is queued, loaded by the back end and sent through its output register;
// integers run the 64-step binary-to-BCD loop in the back end before sign and digits.
// Throughput: one output byte per cycle while the receiver is ready; each token also
// needs one command load in the back end. Depends on jte_pkg, jte_if.
// Reset (rst_n, async, active low) empties the queue, zeroes depth/comma/pretty.
`include "json_token_emitter_assert.svh"

module json_token_emitter import jte_pkg::*; #(
    parameter int MAX_DEPTH = JTE_MAX_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    jte_in_if.sink    in_ch,
    jte_out_if.source out_ch
);

    // Front end: checks and classifies each token against the container
    // stack, and turns it into one byte command (or none for silent tokens).
    cmd_t push_cmd, head_cmd;
    logic push, pop, q_full, q_empty;

    jte_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (push),
        .q_cmd  (push_cmd)
    );

    // Short queue: the front keeps taking tokens while the back drains
    // a long escape, indent run or integer.
    jte_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Back end: byte sequencer with a registered output stage.
    jte_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (head_cmd),
        .q_pop   (pop),
        .out_ch  (out_ch)
    );

    // An error transaction is always a lone, final zero byte.
    `JTE_ASSERT_SAME(a_err_last, out_ch.valid && out_ch.error != ERR_NONE, out_ch.last)
    `JTE_ASSERT_SAME(a_err_zero, out_ch.valid && out_ch.error != ERR_NONE, out_ch.out_byte == 8'h00)
    // Queue full holds the front off.
    `JTE_ASSERT_SAME(a_full_stall, q_full, !in_ch.ready)

endmodule

// ===== bench/tb_json_token_emitter.sv =====
// Testbench for json_token_emitter: drives JSON writer tokens, predicts the text
// byte by byte and checks every output transaction. Depends on jte_pkg, jte_if
// and the RTL of the block.
`timescale 1ns / 100ps

module tb_json_token_emitter;
    import jte_pkg::*;

    localparam int MAX_DEP = JTE_MAX_DEPTH;
    localparam int CYCLE_LIMIT = 600000;

    // One expected output transaction.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [2:0] err;
    } text_byte_t;

    // Scoreboard: holds the writer state and the queue of predicted text bytes.
    class json_text_board;
        bit         kind_stack[MAX_DEP];
        int         depth;
        bit         comma_due;
        bit         pretty;
        text_byte_t pending[$];
        int         errors;
        int         checked;
        int         error_results;

        function void clear();
            depth = 0;
            comma_due = 0;
            pretty = 0;
            pending.delete();
            errors = 0;
            checked = 0;
            error_results = 0;
        endfunction

        function void emit(byte unsigned c);
            text_byte_t t;
            t.ch = c;
            t.last = 0;
            t.err = ERR_NONE;
            pending.push_back(t);
        endfunction

        function void emit_indent();
            emit(8'h0a);
            for (int k = 0; k < depth; k++)
            begin
                emit(" ");
                emit(" ");
            end
        endfunction

        function void emit_error(logic [2:0] code);
            text_byte_t t;
            t.ch = 8'h00;
            t.last = 1;
            t.err = code;
            pending.push_back(t);
        endfunction

        function void emit_escaped(byte unsigned c);
            string hexd;
            hexd = "0123456789abcdef";
            case (c)
                8'h22: begin emit("\\"); emit(8'h22); end
                8'h5c: begin emit("\\"); emit("\\"); end
                8'h0a: begin emit("\\"); emit("n"); end
                8'h0d: begin emit("\\"); emit("r"); end
                8'h09: begin emit("\\"); emit("t"); end
                8'h0c: begin emit("\\"); emit("f"); end
                8'h08: begin emit("\\"); emit("b"); end
                default:
                begin
                    if (c < 8'h20)
                    begin
                        emit("\\"); emit("u"); emit("0"); emit("0");
                        emit(hexd[c[7:4]]);
                        emit(hexd[c[3:0]]);
                    end
                    else
                        emit(c);
                end
            endcase
        endfunction

        function void emit_decimal(logic [63:0] v);
            logic [63:0] mag;
            byte unsigned digs[$];
            mag = v;
            if (v[63])
            begin
                emit("-");
                mag = ~v + 64'd1;
            end
            do
            begin
                digs.push_front(8'd48 + 8'(mag % 10));
                mag = mag / 10;
            end while (mag != 0);
            foreach (digs[i])
                emit(digs[i]);
        endfunction

        // Note an accepted token and queue the text it produces.
        function void note_token(logic [3:0] act, logic pm, logic [7:0] db, logic [63:0] num);
            int prior_count;
            prior_count = pending.size();
            case (act)
                ACT_OPEN_OBJ, ACT_OPEN_ARR:
                begin
                    if (depth >= MAX_DEP)
                    begin
                        emit_error(ERR_TOO_DEEP);
                        return;
                    end
                    pretty = pm;
                    emit(act == ACT_OPEN_OBJ ? "{" : "[");
                    kind_stack[depth] = (act == ACT_OPEN_OBJ);
                    depth++;
                    comma_due = 0;
                end
                ACT_CLOSE:
                begin
                    if (depth == 0)
                    begin
                        emit_error(ERR_CLOSE);
                        return;
                    end
                    depth--;
                    comma_due = 1;
                    if (pretty)
                        emit_indent();
                    emit(kind_stack[depth] ? "}" : "]");
                end
                ACT_ITEM:
                begin
                    if (depth == 0)
                    begin
                        emit_error(ERR_ITEM);
                        return;
                    end
                    if (comma_due)
                        emit(",");
                    else
                        comma_due = 1;
                    if (pretty)
                        emit_indent();
                end
                ACT_QUOTE:   emit(8'h22);
                ACT_STRING:  emit_escaped(db);
                ACT_COLON:
                begin
                    if (depth == 0 || !kind_stack[depth-1])
                    begin
                        emit_error(ERR_COLON);
                        return;
                    end
                    emit(":");
                    if (pretty)
                        emit(" ");
                end
                ACT_LITERAL: emit(db);
                ACT_INTEGER: emit_decimal(num);
                default: ;
            endcase
            if (pending.size() > prior_count)
                pending[pending.size()-1].last = 1;
        endfunction

        // Compare one output transaction with the oldest prediction.
        function void check_byte(logic [7:0] ch, logic last, logic [2:0] err);
            text_byte_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected output byte %h last %b error %0d", $time, ch, last, err);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (err != ERR_NONE)
                error_results++;
            if (e.ch !== ch || e.last !== last || e.err !== err)
            begin
                $display("%0t: mismatch expected byte %h last %b error %0d, got %h %b %0d",
                         $time, e.ch, e.last, e.err, ch, last, err);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    bit   hold_off;      // long receiver stall requested by stimulus
    bit   stim_done;
    bit   random_phase;

    jte_in_if  in_ch();
    jte_out_if out_ch();

    json_token_emitter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    json_text_board board;

    initial clk = 0;
    always #4 clk = ~clk;

    // Token record for the stimulus queue.
    typedef struct {
        logic [3:0]  act;
        logic        pm;
        logic [7:0]  db;
        logic [63:0] num;
    } token_t;

    token_t tokens[$];

    function automatic logic [63:0] rand_number();
        case ($urandom_range(0, 5))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return 64'(int'($urandom_range(0, 20)) - 10);
            3: return {$urandom, $urandom};
            default: return 64'($urandom_range(0, 99999));
        endcase
    endfunction

    function automatic void add(logic [3:0] a, logic p, logic [7:0] d, logic [63:0] n);
        token_t t;
        t.act = a; t.pm = p; t.db = d; t.num = n;
        tokens.push_back(t);
    endfunction

    // Well-formed document fragment with random content, depth-limited.
    function automatic void add_value(int lvl);
        int kind;
        int n;
        kind = (lvl >= 4) ? $urandom_range(2, 4) : $urandom_range(0, 4);
        case (kind)
            0, 1:
            begin
                add(kind == 0 ? ACT_OPEN_OBJ : ACT_OPEN_ARR, 1'($urandom_range(0, 1)), 0, 0);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                begin
                    add(ACT_ITEM, 0, 0, 0);
                    if (kind == 0)
                    begin
                        add(ACT_QUOTE, 0, 0, 0);
                        add(ACT_STRING, 0, 8'(8'h61 + $urandom_range(0, 25)), 0);
                        add(ACT_QUOTE, 0, 0, 0);
                        add(ACT_COLON, 0, 0, 0);
                    end
                    add_value(lvl + 1);
                end
                add(ACT_CLOSE, 0, 0, 0);
            end
            2:
            begin
                add(ACT_QUOTE, 0, 0, 0);
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                    add(ACT_STRING, 0, 8'($urandom_range(0, 255)), 0);
                add(ACT_QUOTE, 0, 0, 0);
            end
            3: add(ACT_INTEGER, 0, 0, rand_number());
            default: add(ACT_LITERAL, 0, 8'($urandom_range(0, 255)), 0);
        endcase
    endfunction

    // Sender: bursts of transactions with random gaps.
    task automatic send_tokens();
        int burst;
        int gap;
        burst = 0;
        while (tokens.size() > 0)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                gap = $urandom_range(0, 4);
                if (gap > 0)
                begin
                    in_ch.valid <= 0;
                    repeat (gap)
                        @(posedge clk);
                end
            end
            in_ch.valid       <= 1;
            in_ch.action      <= tokens[0].act;
            in_ch.pretty_mode <= tokens[0].pm;
            in_ch.data_byte   <= tokens[0].db;
            in_ch.number      <= tokens[0].num;
            @(posedge clk);
            while (!in_ch.ready)
                @(posedge clk);
            board.note_token(tokens[0].act, tokens[0].pm, tokens[0].db, tokens[0].num);
            void'(tokens.pop_front());
            burst--;
            if (tokens.size() == 0)
                in_ch.valid <= 0;
        end
    endtask

    // Drain the block completely before the next phase.
    task automatic wait_idle();
        while (board.pending.size() > 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
    endtask

    // Receiver: stalls on its own pattern, plus the long hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 0;
        else if (hold_off)
            out_ch.ready <= 0;
        else
            case ((cycles / 64) % 3)
                0: out_ch.ready <= 1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: out_ch.ready <= ($urandom_range(0, 1) != 0);
            endcase
    end

    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_byte(out_ch.out_byte, out_ch.last, out_ch.error);

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL json_token_emitter");
            $finish;
        end
    end

    // Long receiver stall, counted here while the sender keeps going.
    initial
    begin
        hold_off = 0;
        wait (random_phase && !stim_done);
        repeat (50)
            @(posedge clk);
        hold_off = 1;
        repeat (400)
            @(posedge clk);
        hold_off = 0;
    end

    initial
    begin
        board = new();
        board.clear();
        cycles = 0;
        stim_done = 0;
        random_phase = 0;
        rst_n = 0;
        in_ch.valid = 0;
        in_ch.action = ACT_OPEN_OBJ;
        in_ch.pretty_mode = 0;
        in_ch.data_byte = 0;
        in_ch.number = 0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: misuse at top level, every action, escapes, extremes.
        add(ACT_CLOSE, 0, 0, 0);
        add(ACT_ITEM, 0, 0, 0);
        add(ACT_COLON, 0, 0, 0);
        add(ACT_QUOTE, 0, 0, 0);
        add(ACT_LITERAL, 0, 8'hff, 0);
        add(ACT_INTEGER, 0, 0, 64'h8000_0000_0000_0000);
        add(ACT_INTEGER, 0, 0, 64'h7fff_ffff_ffff_ffff);
        add(ACT_INTEGER, 0, 0, 64'd0);
        add(4'd15, 1, 8'hff, 64'hffff_ffff_ffff_ffff);
        add(ACT_OPEN_OBJ, 0, 0, 0);
        add(ACT_ITEM, 0, 0, 0);              // compact first item: no output
        add(ACT_STRING, 0, 8'h00, 0);
        add(ACT_STRING, 0, 8'h22, 0);
        add(ACT_STRING, 0, 8'h5c, 0);
        add(ACT_STRING, 0, 8'h1f, 0);
        add(ACT_COLON, 0, 0, 0);
        add(ACT_OPEN_ARR, 1, 0, 0);
        add(ACT_COLON, 0, 0, 0);             // colon inside array
        add(ACT_ITEM, 0, 0, 0);
        add(ACT_ITEM, 0, 0, 0);
        add(ACT_CLOSE, 0, 0, 0);
        add(ACT_CLOSE, 0, 0, 0);
        send_tokens();
        wait_idle();

        // Fill the stack to its limit, overflow once, then unwind pretty.
        for (int i = 0; i <= MAX_DEP; i++)
            add(i[0] ? ACT_OPEN_ARR : ACT_OPEN_OBJ, 1, 0, 0);
        add(ACT_ITEM, 0, 0, 0);
        add(ACT_ITEM, 0, 0, 0);
        for (int i = 0; i < MAX_DEP; i++)
            add(ACT_CLOSE, 0, 0, 0);
        send_tokens();
        wait_idle();

        // Random: mostly well-formed documents, some noise tokens.
        while (tokens.size() < 380)
        begin
            if ($urandom_range(0, 5) == 0)
                add(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)), rand_number());
            else
                add_value(0);
        end
        // keep the stack shallow so stray opens do not pile up
        for (int i = 0; i < MAX_DEP; i++)
            add(ACT_CLOSE, 0, 0, 0);
        random_phase = 1;
        send_tokens();
        stim_done = 1;

        while (board.pending.size() > 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);

        $display("Checked %0d output bytes, %0d of them error results, across nested",
                 board.checked, board.error_results);
        $display("documents, escapes, integers, misuse and a full-depth stack.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS json_token_emitter");
        else
            $display("FAIL json_token_emitter");
        $finish;
    end
endmodule
